FILE: rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

	localparam int TIMER_COUNT  = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int ACTIVE_MAX   = (TIMER_COUNT < RESULT_LIMIT) ? TIMER_COUNT : RESULT_LIMIT;
	localparam int TIMER_IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	localparam int CFG_W   = 5;
	localparam int SEL_W   = 4;
	localparam int COUNT_W = 32;
	localparam int CMD_W   = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DISARM = 2'd2;

	// result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_INDEX = 1'b1;

	// register map, selected by paddr[2]
	localparam logic REG_TIMERS_IN_USE = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [SEL_W-1:0]   timer_select;
		logic [COUNT_W-1:0] first_timeout;
		logic [COUNT_W-1:0] reload_interval;
	} in_item_t;

	typedef struct packed {
		logic             expired;
		logic [SEL_W-1:0] timer_index;
		logic             status;
		logic             last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic step;
		logic flush;
		logic respond;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic new_is_tick;
		logic walk_done;
		logic step_blocked;
		logic out_free;
		logic pend_valid;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/ptb_datapath.sv
// ----------------------------------------------------------------------------
// ptb_datapath
// Timer count storage, walk index, pending expiry and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptb_pkg::in_item_t          cmd_data,
	input  logic [ptb_pkg::CFG_W-1:0]  timers_in_use,
	input  ptb_pkg::ctl_cmd_t          ctl,
	output ptb_pkg::dp_status_t        status,
	output logic                       res_valid,
	input  logic                       res_ready,
	output ptb_pkg::out_item_t         res_data
);

	logic [ptb_pkg::COUNT_W-1:0] rc_q [ptb_pkg::TIMER_COUNT];
	logic [ptb_pkg::COUNT_W-1:0] rv_q [ptb_pkg::TIMER_COUNT];

	ptb_pkg::in_item_t           item_q;
	logic [ptb_pkg::CFG_W-1:0]   idx_q;
	logic                        pend_q;
	logic [ptb_pkg::SEL_W-1:0]   pend_idx_q;
	logic                        res_valid_q;
	ptb_pkg::out_item_t          res_data_q;

	logic [ptb_pkg::CFG_W-1:0]       lim;
	logic [ptb_pkg::TIMER_IDX_W-1:0] rd_addr;
	logic [ptb_pkg::COUNT_W-1:0]     rc_rd;
	logic [ptb_pkg::COUNT_W-1:0]     rv_rd;
	logic                            active;
	logic                            hits;
	logic                            walk_done;
	logic                            is_arm;
	logic                            is_sel_cmd;
	logic                            item_bad;
	logic                            out_free;

	logic                            rc_we;
	logic                            rv_we;
	logic [ptb_pkg::TIMER_IDX_W-1:0] wr_addr;
	logic [ptb_pkg::COUNT_W-1:0]     rc_wdata;
	logic [ptb_pkg::COUNT_W-1:0]     rv_wdata;

	logic                            push;
	ptb_pkg::out_item_t              res_next;

	assign lim = (timers_in_use > ptb_pkg::CFG_W'(ptb_pkg::ACTIVE_MAX)) ?
		ptb_pkg::CFG_W'(ptb_pkg::ACTIVE_MAX) : timers_in_use;

	assign rd_addr   = idx_q[ptb_pkg::TIMER_IDX_W-1:0];
	assign rc_rd     = rc_q[rd_addr];
	assign rv_rd     = rv_q[rd_addr];
	assign active    = (rc_rd != '0);
	assign hits      = (rc_rd == ptb_pkg::COUNT_W'(1));
	assign walk_done = (idx_q >= lim);

	assign is_arm     = (item_q.command == ptb_pkg::CMD_ARM);
	assign is_sel_cmd = is_arm || (item_q.command == ptb_pkg::CMD_DISARM);
	assign item_bad   = is_sel_cmd && ({1'b0, item_q.timer_select} >= lim);

	assign out_free = !res_valid_q || res_ready;

	assign status.new_is_tick  = (cmd_data.command == ptb_pkg::CMD_TICK);
	assign status.walk_done    = walk_done;
	assign status.step_blocked = hits && pend_q && !out_free;
	assign status.out_free     = out_free;
	assign status.pend_valid   = pend_q;

	// one write port: walk step or arm/disarm
	always_comb begin
		rc_we    = 1'b0;
		rv_we    = 1'b0;
		wr_addr  = rd_addr;
		rc_wdata = rc_rd;
		rv_wdata = rv_rd;
		if (ctl.step) begin
			rc_we = active;
			if (hits) begin
				rc_wdata = rv_rd;
			end else begin
				rc_wdata = rc_rd - ptb_pkg::COUNT_W'(1);
			end
		end else if (ctl.respond && is_sel_cmd && !item_bad) begin
			rc_we    = 1'b1;
			rv_we    = 1'b1;
			wr_addr  = ptb_pkg::TIMER_IDX_W'(item_q.timer_select);
			rc_wdata = is_arm ? item_q.first_timeout : '0;
			rv_wdata = is_arm ? item_q.reload_interval : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptb_pkg::TIMER_COUNT; i++) begin
				rc_q[i] <= '0;
				rv_q[i] <= '0;
			end
		end else begin
			if (rc_we) begin
				rc_q[wr_addr] <= rc_wdata;
			end
			if (rv_we) begin
				rv_q[wr_addr] <= rv_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= cmd_data;
		end
	end

	// the held expiry goes out with last=0 once a later one shows up
	always_comb begin
		push     = 1'b0;
		res_next = '0;
		res_next.status = ptb_pkg::STATUS_OK;
		if (ctl.step && hits && pend_q) begin
			push                 = 1'b1;
			res_next.expired     = 1'b1;
			res_next.timer_index = pend_idx_q;
		end else if (ctl.flush) begin
			push          = 1'b1;
			res_next.last = 1'b1;
			if (pend_q) begin
				res_next.expired     = 1'b1;
				res_next.timer_index = pend_idx_q;
			end
		end else if (ctl.respond) begin
			push            = 1'b1;
			res_next.last   = 1'b1;
			res_next.status = item_bad ? ptb_pkg::STATUS_BAD_INDEX : ptb_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (ctl.step) begin
				idx_q <= idx_q + ptb_pkg::CFG_W'(1);
				if (hits) begin
					pend_q <= 1'b1;
				end
			end else if (ctl.flush) begin
				pend_q <= 1'b0;
			end
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && hits) begin
			pend_idx_q <= idx_q[ptb_pkg::SEL_W-1:0];
		end
		if (push) begin
			res_data_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	a_push_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!res_valid_q || res_ready))
		else $error("result register overwritten");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (idx_q < lim))
		else $error("walk step beyond timers in use");

endmodule

`default_nettype wire

FILE: rtl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer for tick walks and arm/disarm responses.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ptb_pkg::dp_status_t status,
	output ptb_pkg::ctl_cmd_t   ctl
);

	ptb_pkg::state_t state_q;
	ptb_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = status.new_is_tick ? ptb_pkg::ST_WALK : ptb_pkg::ST_RESP;
				end
			end
			ptb_pkg::ST_WALK: begin
				if (status.walk_done) begin
					state_d = ptb_pkg::ST_FLUSH;
				end
			end
			ptb_pkg::ST_FLUSH: begin
				if (status.out_free) begin
					state_d = ptb_pkg::ST_IDLE;
				end
			end
			ptb_pkg::ST_RESP: begin
				if (status.out_free) begin
					state_d = ptb_pkg::ST_IDLE;
				end
			end
			default: state_d = ptb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready   = 1'b0;
		ctl         = '0;
		unique case (state_q)
			ptb_pkg::ST_IDLE: begin
				cmd_ready   = 1'b1;
				ctl.capture = cmd_valid;
			end
			ptb_pkg::ST_WALK: begin
				ctl.step = !status.walk_done && !status.step_blocked;
			end
			ptb_pkg::ST_FLUSH: begin
				ctl.flush = status.out_free;
			end
			ptb_pkg::ST_RESP: begin
				ctl.respond = status.out_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptb_pkg::ST_IDLE) |-> !status.pend_valid)
		else $error("expiry left pending after walk");

endmodule

`default_nettype wire

FILE: rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of tick-driven one-shot/periodic countdown timers with expiry reports.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  notes
//  cmd       cmd_valid/cmd_ready/cmd_data     in         tick, arm, disarm
//  res       res_valid/res_ready/res_data     out        one or more per item
//  apb       psel/penable/pwrite/paddr/...    in/out     timers_in_use at 0x0
//
// an arm/disarm result is registered once the result register is free; the next item waits for that push
// a tick walks one timer per cycle unless a stalled result register blocks the step, then flushes a last result
// one item at a time; a new item is taken while the last result still waits
// a stalled result register holds the walk at the next expiring timer
// reset clears all counts and reloads at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ptb_pkg::in_item_t  cmd_data,
	output logic               res_valid,
	input  logic               res_ready,
	output ptb_pkg::out_item_t res_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [ptb_pkg::CFG_W-1:0] timers_in_use_q;
	ptb_pkg::ctl_cmd_t         ctl;
	ptb_pkg::dp_status_t       status;
	logic                      reg_hit;

	assign reg_hit = (paddr[2] == ptb_pkg::REG_TIMERS_IN_USE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(32 - ptb_pkg::CFG_W){1'b0}}, timers_in_use_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timers_in_use_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			timers_in_use_q <= pwdata[ptb_pkg::CFG_W-1:0];
		end
	end

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.status    (status),
		.ctl       (ctl)
	);

	ptb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_data      (cmd_data),
		.timers_in_use (timers_in_use_q),
		.ctl           (ctl),
		.status        (status),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_data      (res_data)
	);

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("second item taken during processing");

endmodule

`default_nettype wire

FILE: dv/periodic_timer_bank_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_checker
// Watches the command, result and register channels of the timer bank. Keeps
// its own copy of the timer counts and reloads, works out the expiry reports
// each accepted item should produce and compares every result against them.
// ----------------------------------------------------------------------------

module periodic_timer_bank_checker
	import ptb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  in_item_t    cmd_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  out_item_t   res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned err_count,
	output int unsigned open_count
);

	localparam int unsigned REPORT_LIMIT = 10;

	logic [COUNT_W-1:0] ticks_left   [TIMER_COUNT];
	logic [COUNT_W-1:0] reload_ticks [TIMER_COUNT];
	logic [CFG_W-1:0]   timers_walked;
	out_item_t          expected_reports [$];
	int unsigned        mismatches = 0;

	task automatic apply_command(input in_item_t it);
		int unsigned lim;
		out_item_t   report;
		out_item_t   held;
		logic        have_held;
		lim = (timers_walked > ACTIVE_MAX) ? ACTIVE_MAX : timers_walked;
		report = '0;
		report.status = STATUS_OK;
		report.last = 1'b1;
		held = '0;
		have_held = 1'b0;
		case (it.command)
			CMD_TICK: begin
				for (int i = 0; i < lim; i++) begin
					if (ticks_left[i] != '0) begin
						ticks_left[i] = ticks_left[i] - 1'b1;
						if (ticks_left[i] == '0) begin
							// hold back one report so the final one can carry last
							if (have_held)
								expected_reports.push_back(held);
							held = '0;
							held.expired = 1'b1;
							held.timer_index = SEL_W'(i);
							held.status = STATUS_OK;
							have_held = 1'b1;
							ticks_left[i] = reload_ticks[i];
						end
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					expected_reports.push_back(held);
				end else begin
					expected_reports.push_back(report);
				end
			end
			CMD_ARM, CMD_DISARM: begin
				if (it.timer_select >= lim) begin
					report.status = STATUS_BAD_INDEX;
				end else if (it.command == CMD_ARM) begin
					ticks_left[it.timer_select] = it.first_timeout;
					reload_ticks[it.timer_select] = it.reload_interval;
				end else begin
					ticks_left[it.timer_select] = '0;
					reload_ticks[it.timer_select] = '0;
				end
				expected_reports.push_back(report);
			end
			default: begin
				expected_reports.push_back(report);
			end
		endcase
	endtask

	task automatic check_report(input out_item_t got);
		out_item_t want;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected result expired=%0b index=%0d status=%0b last=%0b",
					$time, got.expired, got.timer_index, got.status, got.last);
		end else begin
			want = expected_reports.pop_front();
			if (got.expired !== want.expired || got.timer_index !== want.timer_index ||
			    got.status !== want.status || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result mismatch expected expired=%0b index=%0d status=%0b last=%0b, got expired=%0b index=%0d status=%0b last=%0b",
						$time, want.expired, want.timer_index, want.status, want.last,
						got.expired, got.timer_index, got.status, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				ticks_left[i] = '0;
				reload_ticks[i] = '0;
			end
			timers_walked = '0;
			expected_reports.delete();
		end else begin
			if (res_valid && res_ready)
				check_report(res_data);
			if (cmd_valid && cmd_ready)
				apply_command(cmd_data);
			if (psel && penable && pwrite && pready && paddr[2] == REG_TIMERS_IN_USE)
				timers_walked = pwdata[CFG_W-1:0];
		end
		open_count <= expected_reports.size();
		err_count <= mismatches;
	end

endmodule

FILE: dv/periodic_timer_bank_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_test
// Drives the timer bank with directed arm/disarm/tick items and then random
// phases at several timers_in_use settings, with bursty commands, a stalling
// result consumer and one long result hold-off. The checker does the compare.
// ----------------------------------------------------------------------------

module periodic_timer_bank_test;
	import ptb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
	localparam int unsigned      RANDOM_ITEMS   = 250;
	localparam int unsigned      LONG_HOLD      = 300;
	localparam int unsigned      WATCHDOG_LIMIT = 2000;
	localparam int unsigned      PHASES         = 7;
	localparam logic [CFG_W-1:0] CFG_PLAN [PHASES] = '{
		5'd31, 5'd5, 5'd1, 5'd16, 5'd0, 5'd9, 5'd16
	};

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	in_item_t    cmd_data;
	logic        res_valid;
	logic        res_ready;
	out_item_t   res_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned err_count;
	int unsigned open_count;
	int unsigned burst_left = 0;
	int unsigned stalled_cycles = 0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;

	periodic_timer_bank dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data (cmd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	periodic_timer_bank_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.err_count (err_count),
		.open_count(open_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_item_t cmd_item(input logic [CMD_W-1:0] c,
		input logic [SEL_W-1:0] s, input logic [COUNT_W-1:0] f,
		input logic [COUNT_W-1:0] r);
		in_item_t it;
		it.command = c;
		it.timer_select = s;
		it.first_timeout = f;
		it.reload_interval = r;
		return it;
	endfunction

	// offer one item, with a random gap whenever a burst runs out
	task automatic offer_cmd(input in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd_data <= it;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// drain all outstanding results, then let the walk settle
	task automatic wait_quiet();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (ACTIVE_MAX + 4) @(posedge clk);
	endtask

	task automatic write_timers_in_use(input logic [CFG_W-1:0] n);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TIMERS_IN_USE, 2'b00};
		pwdata <= 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// result consumer: random stall patterns plus one long hold-off on request
	initial begin
		int unsigned mode;
		int unsigned span;
		res_ready <= 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(10, 60);
				repeat (span) begin
					// start the hold-off right away while items are still coming
					if (hold_req && !hold_done)
						break;
					case (mode)
						0: res_ready <= 1'b1;
						1: res_ready <= 1'($urandom_range(0, 1));
						default: res_ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		in_item_t    it;
		int unsigned counted;
		int unsigned target;
		int unsigned lim;
		int unsigned roll;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing in use after reset: every arm/disarm is out of range
		offer_cmd(cmd_item(CMD_TICK, 4'd0, '0, '0));
		offer_cmd(cmd_item(CMD_ARM, 4'd0, 32'd1, 32'd1));
		offer_cmd(cmd_item(CMD_DISARM, 4'd15, '0, '0));
		offer_cmd(cmd_item(CMD_UNUSED, 4'hF, '1, '1));
		wait_quiet();
		write_timers_in_use(5'(ACTIVE_MAX));

		// all timers expire on one tick, mix of one-shot and periodic
		for (int i = 0; i < ACTIVE_MAX; i++)
			offer_cmd(cmd_item(CMD_ARM, SEL_W'(i), 32'd1, 32'(i % 3)));
		offer_cmd(cmd_item(CMD_TICK, 4'd0, '0, '0));
		offer_cmd(cmd_item(CMD_TICK, 4'hF, '1, '1));
		// zero first timeout leaves the timer idle
		offer_cmd(cmd_item(CMD_ARM, 4'd15, '0, '1));
		offer_cmd(cmd_item(CMD_ARM, 4'd14, '1, '1));
		offer_cmd(cmd_item(CMD_DISARM, 4'd13, '0, '0));
		offer_cmd(cmd_item(CMD_TICK, 4'd0, '0, '0));

		counted = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_quiet();
			write_timers_in_use(CFG_PLAN[phase]);
			lim = (CFG_PLAN[phase] > ACTIVE_MAX) ? ACTIVE_MAX : CFG_PLAN[phase];
			target = (phase + 1) * RANDOM_ITEMS / PHASES;
			while (counted < target) begin
				it = cmd_item(CMD_TICK, SEL_W'($urandom_range(0, 15)), $urandom, $urandom);
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					it.command = CMD_TICK;
				end else if (roll < 92) begin
					it.command = (roll < 80) ? CMD_ARM : CMD_DISARM;
					if (lim > 0 && roll % 12 != 0)
						it.timer_select = SEL_W'($urandom_range(0, lim - 1));
					case ($urandom_range(0, 7))
						0: it.first_timeout = '0;
						1: ;
						default: it.first_timeout = $urandom_range(1, 6);
					endcase
					case ($urandom_range(0, 7))
						0, 1: it.reload_interval = '0;
						2: ;
						default: it.reload_interval = $urandom_range(1, 5);
					endcase
				end else if (roll < 96) begin
					it.command = CMD_UNUSED;
				end else begin
					// any index, often past the timers in use
					it.command = roll[0] ? CMD_ARM : CMD_DISARM;
				end
				if (it.command != CMD_UNUSED)
					counted++;
				if (phase == 1 && counted == target - 20)
					hold_req <= 1'b1;
				offer_cmd(it);
			end
		end

		wait_quiet();
		if (err_count == 0 && open_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
